[hw/rtl/bfla_pkg.sv]
`timescale 1ns / 1ps

package bfla_pkg;

  localparam int IdxW = 6;
  localparam int DefBufferCount = 64;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e            command;
    logic [IdxW-1:0] buffer_index;
  } in_t;

  typedef struct packed {
    logic [IdxW-1:0] granted_index;
    logic            out_of_buffers;
  } out_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ALLOC,
    ST_RESULT
  } state_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_OOB,
    RES_GRANT
  } res_kind_e;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      pop;
    logic      push;
    logic      sweep_start;
    logic      sweep_step;
    logic      load_out;
    res_kind_e out_kind;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic head_empty;
    logic idx_ok;
    logic sweep_last;
    logic out_free;
  } ctl_sts_t;

endpackage

[hw/rtl/buffer_free_list_allocator_unit.sv]
// Free and the unused command finish when accepted; allocate reads the head's link
//   through the registered read port of the link store, then pops it, or reports out
//   of buffers at once when the list is empty; init relinks all BufferCount entries.
// Throughput: one item at a time; a new item is taken once the previous one is done.
// The output register holds a finished result while the next item is accepted.
// Reset: the link store is relinked by a sweep over all BufferCount entries with in_ready_o low.
`timescale 1ns / 1ps

module buffer_free_list_allocator_unit #(
  parameter int BufferCount = bfla_pkg::DefBufferCount
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bfla_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bfla_pkg::out_t out_data_o
);

  bfla_pkg::ctl_cmd_t ctl_cmd;
  bfla_pkg::ctl_sts_t ctl_sts;

  bfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.command),
    .sts_i      (ctl_sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (ctl_cmd)
  );

  bfla_datapath #(
    .BufferCount (BufferCount)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (ctl_cmd),
    .sts_o       (ctl_sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[hw/rtl/bfla_ctrl.sv]
`timescale 1ns / 1ps

module bfla_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bfla_pkg::cmd_e      in_cmd_i,
  input  bfla_pkg::ctl_sts_t  sts_i,
  output logic                in_ready_o,
  output bfla_pkg::ctl_cmd_t  cmd_o
);

  bfla_pkg::state_e    state_q, state_d;
  bfla_pkg::res_kind_e kind_q, kind_d;
  logic                init_pend_q, init_pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfla_pkg::ST_SWEEP;
      kind_q      <= bfla_pkg::RES_ZERO;
      init_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      init_pend_q <= init_pend_d;
    end
  end

  always_comb begin
    logic                finish;
    bfla_pkg::res_kind_e fin_kind;

    finish      = 1'b0;
    fin_kind    = bfla_pkg::RES_ZERO;
    state_d     = state_q;
    kind_d      = kind_q;
    init_pend_d = init_pend_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.out_kind = bfla_pkg::RES_ZERO;

    unique case (state_q)
      bfla_pkg::ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          init_pend_d = 1'b0;
          if (init_pend_q) begin
            finish   = 1'b1;
            fin_kind = bfla_pkg::RES_ZERO;
          end else begin
            state_d = bfla_pkg::ST_IDLE;
          end
        end
      end
      bfla_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (in_cmd_i)
            bfla_pkg::CMD_ALLOC: begin
              if (sts_i.head_empty) begin
                finish   = 1'b1;
                fin_kind = bfla_pkg::RES_OOB;
              end else begin
                // link of the head comes back from the store next cycle
                state_d = bfla_pkg::ST_ALLOC;
              end
            end
            bfla_pkg::CMD_FREE: begin
              cmd_o.push = sts_i.idx_ok;
              finish     = 1'b1;
            end
            bfla_pkg::CMD_INIT: begin
              cmd_o.sweep_start = 1'b1;
              init_pend_d       = 1'b1;
              state_d           = bfla_pkg::ST_SWEEP;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      bfla_pkg::ST_ALLOC: begin
        cmd_o.pop = 1'b1;
        finish    = 1'b1;
        fin_kind  = bfla_pkg::RES_GRANT;
      end
      bfla_pkg::ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = kind_q;
          state_d        = bfla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bfla_pkg::ST_IDLE;
      end
    endcase

    // hand the result to the output register, or park it until there is room
    if (finish) begin
      if (sts_i.out_free) begin
        cmd_o.load_out = 1'b1;
        cmd_o.out_kind = fin_kind;
        state_d        = bfla_pkg::ST_IDLE;
      end else begin
        kind_d  = fin_kind;
        state_d = bfla_pkg::ST_RESULT;
      end
    end
  end

endmodule

[hw/rtl/bfla_datapath.sv]
`timescale 1ns / 1ps

module bfla_datapath #(
  parameter int BufferCount = bfla_pkg::DefBufferCount
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfla_pkg::in_t      in_data_i,
  input  logic               out_ready_i,
  input  bfla_pkg::ctl_cmd_t cmd_i,
  output bfla_pkg::ctl_sts_t sts_o,
  output logic               out_valid_o,
  output bfla_pkg::out_t     out_data_o
);

  localparam int AddrW = $clog2(BufferCount);
  localparam int LinkW = $clog2(BufferCount + 1);
  localparam logic [LinkW-1:0] ListEnd  = LinkW'(BufferCount);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(BufferCount - 1);

  logic [LinkW-1:0] links [BufferCount];

  logic [LinkW-1:0]         head_q, head_d;
  logic [AddrW-1:0]         cnt_q, cnt_d;
  logic [LinkW-1:0]         rd_data_q;
  logic [bfla_pkg::IdxW-1:0] grant_q;
  logic                     out_valid_q, out_valid_d;
  bfla_pkg::out_t           out_q, out_d;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [LinkW-1:0] wr_data;

  assign sts_o.head_empty = (head_q == ListEnd);
  assign sts_o.idx_ok     = (32'(in_data_i.buffer_index) < 32'(BufferCount));
  assign sts_o.sweep_last = (cnt_q == LastAddr);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // one write port: relink sweep or a push
  always_comb begin
    wr_en   = cmd_i.sweep_step || cmd_i.push;
    wr_addr = AddrW'(in_data_i.buffer_index);
    wr_data = head_q;
    if (cmd_i.sweep_step) begin
      wr_addr = cnt_q;
      wr_data = (cnt_q == LastAddr) ? ListEnd : LinkW'(cnt_q) + LinkW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      links[wr_addr] <= wr_data;
    end
    rd_data_q <= links[head_q[AddrW-1:0]];
  end

  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    if (cmd_i.sweep_start) begin
      head_d = '0;
      cnt_d  = '0;
    end else if (cmd_i.sweep_step) begin
      cnt_d = cnt_q + AddrW'(1);
    end else if (cmd_i.pop) begin
      head_d = rd_data_q;
    end else if (cmd_i.push) begin
      head_d = LinkW'(in_data_i.buffer_index);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d          = 1'b1;
      out_d.granted_index  = (cmd_i.out_kind == bfla_pkg::RES_GRANT) ? grant_q : '0;
      out_d.out_of_buffers = (cmd_i.out_kind == bfla_pkg::RES_OOB);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.capture) begin
      grant_q <= bfla_pkg::IdxW'(head_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/bfla_checker.sv]
`timescale 1ns / 1ps

module bfla_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input bfla_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input bfla_pkg::out_t out_data_o
);

  logic [1:0] outst_q, outst_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // transactions accepted but not yet delivered
  always_comb begin
    outst_d = outst_q;
    if (in_acc && !out_acc) begin
      outst_d = outst_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      outst_d = outst_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_oob_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_of_buffers |-> out_data_o.granted_index == '0)
    else $error("failed allocate carries an index");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outst_q != 2'd0)
    else $error("result without a pending transaction");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q != 2'd3)
    else $error("too many transactions in flight");

endmodule

bind buffer_free_list_allocator_unit bfla_checker u_bfla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
